// ===== design/drt_pkg.sv =====
`timescale 1ns / 1ps
package drt_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 64;
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned ADV_W = 16;
  localparam int unsigned CMD_W = 3;
  localparam int unsigned COST_W = 5;
  localparam int unsigned AGE_W = 6;

  localparam logic [COST_W-1:0] COST_INF = 5'd16;
  localparam logic [COST_W-1:0] COST_DIRECT = 5'd1;
  localparam logic [AGE_W-1:0] AGE_MAX = 6'd63;
  localparam logic [AGE_W-1:0] EXPIRE_RESET = 6'd12;

  // Command codes of the input channel
  localparam logic [CMD_W-1:0] CMD_ADVERTISE = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 3'd1;
  localparam logic [CMD_W-1:0] CMD_KEEPALIVE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TICK = 3'd3;
  localparam logic [CMD_W-1:0] CMD_LINK = 3'd4;

  typedef enum logic [2:0] {
    OP_ADV,
    OP_LOOKUP,
    OP_KEEP,
    OP_TICK,
    OP_LINK,
    OP_NONE
  } op_e;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [ADDR_W-1:0] dest_address;
    logic [ADV_W-1:0] adv_cost;
    logic [ADDR_W-1:0] source_address;
    logic link_up;
  } item_t;

  typedef struct packed {
    op_e op;
    item_t item;
  } qent_t;

  typedef struct packed {
    logic changed;
    logic found;
    logic [ADDR_W-1:0] next_hop;
    logic [COST_W-1:0] route_cost;
    logic table_full;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND_RD,
    S_FIND_CHK,
    S_APPLY,
    S_KA_RD,
    S_KA_CHK,
    S_AGE_RD,
    S_AGE_CHK,
    S_EXP_RD,
    S_EXP_CHK,
    S_INV_RD,
    S_INV_CHK,
    S_DONE
  } state_e;

  // Sort a command code into an operation
  function automatic op_e classify(input logic [CMD_W-1:0] cmd);
    op_e op;
    case (cmd)
      CMD_ADVERTISE: op = OP_ADV;
      CMD_LOOKUP: op = OP_LOOKUP;
      CMD_KEEPALIVE: op = OP_KEEP;
      CMD_TICK: op = OP_TICK;
      CMD_LINK: op = OP_LINK;
      default: op = OP_NONE;
    endcase
    return op;
  endfunction

endpackage

// ===== design/drt_if.sv =====
`timescale 1ns / 1ps
interface drt_in_if;
  logic valid;
  logic ready;
  logic [2:0] cmd;
  logic [31:0] dest_address;
  logic [15:0] adv_cost;
  logic [31:0] source_address;
  logic link_up;

  modport source (output valid, cmd, dest_address, adv_cost, source_address, link_up,
                  input ready);
  modport sink (input valid, cmd, dest_address, adv_cost, source_address, link_up,
                output ready);
endinterface

interface drt_out_if;
  logic valid;
  logic ready;
  logic changed;
  logic found;
  logic [31:0] next_hop;
  logic [4:0] route_cost;
  logic table_full;

  modport source (output valid, changed, found, next_hop, route_cost, table_full,
                  input ready);
  modport sink (input valid, changed, found, next_hop, route_cost, table_full,
                output ready);
endinterface

// ===== design/drt_cmd_fifo.sv =====
`timescale 1ns / 1ps
module drt_cmd_fifo
  import drt_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  drt_in_if.sink in_ch,
  output logic   q_valid_o,
  output qent_t  q_entry_o,
  input  logic   q_pop_i
);

  qent_t      mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;
  item_t      item;

  assign in_ch.ready = (cnt_q != 2'd2);
  assign push = in_ch.valid && in_ch.ready;
  assign pop = q_pop_i && (cnt_q != 2'd0);
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_entry_o = mem_q[rd_ptr_q];

  assign item = '{cmd: in_ch.cmd, dest_address: in_ch.dest_address,
                  adv_cost: in_ch.adv_cost, source_address: in_ch.source_address,
                  link_up: in_ch.link_up};

  // Store the classified transfer
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= '{op: classify(in_ch.cmd), item: item};
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== design/drt_engine.sv =====
`timescale 1ns / 1ps
module drt_engine
  import drt_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [5:0]    cfg_wdata_i,
  input  logic          q_valid_i,
  input  qent_t         q_entry_i,
  output logic          q_pop_o,
  drt_out_if.source     out_ch
);

  localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_ENTRIES);

  // Route storage
  logic [ADDR_W-1:0] dest_mem [TABLE_ENTRIES];
  logic [ADDR_W-1:0] hop_mem [TABLE_ENTRIES];
  logic [COST_W-1:0] met_mem [TABLE_ENTRIES];
  logic [AGE_W-1:0]  age_mem [TABLE_ENTRIES];

  logic [ADDR_W-1:0] rd_dest, rd_hop;
  logic [COST_W-1:0] rd_met;
  logic [AGE_W-1:0]  rd_age;

  logic              we_dest, we_hop, we_met, we_age;
  logic [IW-1:0]     waddr, raddr;
  logic [ADDR_W-1:0] wdest, whop;
  logic [COST_W-1:0] wmet;
  logic [AGE_W-1:0]  wage;

  state_e            state_q, state_d;
  qent_t             cur_q, cur_d;
  logic [IW-1:0]     idx_q, idx_d, jdx_q, jdx_d, ent_q, ent_d;
  logic [CW-1:0]     fill_q, fill_d;
  logic              found_q, found_d;
  logic [ADDR_W-1:0] mhop_q, mhop_d, inv_dest_q, inv_dest_d;
  logic [COST_W-1:0] mmet_q, mmet_d;
  logic [AGE_W-1:0]  expire_q;
  result_t           res_q, res_d, out_q, out_d;
  logic              out_valid_q, out_valid_d;

  logic              tbl_empty, tbl_full, last_i, last_j, out_free;
  logic              dest_hit, improve, expired;
  logic [ADV_W:0]    adv_inc;
  logic [COST_W-1:0] sat_cost;

  assign tbl_empty = (fill_q == '0);
  assign tbl_full = (fill_q == FULL_CNT);
  assign last_i = (CW'(idx_q) == fill_q - CW'(1));
  assign last_j = (CW'(jdx_q) == fill_q - CW'(1));
  assign out_free = !out_valid_q || out_ch.ready;
  assign dest_hit = (rd_dest == cur_q.item.dest_address);
  assign adv_inc = {1'b0, cur_q.item.adv_cost} + (ADV_W + 1)'(1);
  assign improve = ({{(ADV_W + 1 - COST_W){1'b0}}, mmet_q} > adv_inc);
  assign sat_cost = (cur_q.item.adv_cost >= ADV_W'(COST_INF)) ? COST_INF
                  : COST_W'(adv_inc);
  assign expired = (rd_age > expire_q);

  assign raddr = (state_q == S_INV_RD) ? jdx_q : idx_q;

  // Write and read the route memories
  always_ff @(posedge clk_i) begin
    if (we_dest) dest_mem[waddr] <= wdest;
    rd_dest <= dest_mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (we_hop) hop_mem[waddr] <= whop;
    rd_hop <= hop_mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (we_met) met_mem[waddr] <= wmet;
    rd_met <= met_mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (we_age) age_mem[waddr] <= wage;
    rd_age <= age_mem[raddr];
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          case (q_entry_i.op)
            OP_TICK: state_d = tbl_empty ? S_DONE : S_AGE_RD;
            OP_NONE: state_d = S_DONE;
            default: state_d = tbl_empty ? S_APPLY : S_FIND_RD;
          endcase
        end
      end
      S_FIND_RD: state_d = S_FIND_CHK;
      S_FIND_CHK: begin
        if (dest_hit || last_i) state_d = S_APPLY;
        else state_d = S_FIND_RD;
      end
      S_APPLY: begin
        if (cur_q.op == OP_KEEP && found_q) state_d = S_KA_RD;
        else state_d = S_DONE;
      end
      S_KA_RD: state_d = S_KA_CHK;
      S_KA_CHK: state_d = last_i ? S_DONE : S_KA_RD;
      S_AGE_RD: state_d = S_AGE_CHK;
      S_AGE_CHK: state_d = last_i ? S_EXP_RD : S_AGE_RD;
      S_EXP_RD: state_d = S_EXP_CHK;
      S_EXP_CHK: begin
        if (expired) state_d = S_INV_RD;
        else if (last_i) state_d = S_DONE;
        else state_d = S_EXP_RD;
      end
      S_INV_RD: state_d = S_INV_CHK;
      S_INV_CHK: begin
        if (!last_j) state_d = S_INV_RD;
        else if (last_i) state_d = S_DONE;
        else state_d = S_EXP_RD;
      end
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and memory writes
  always_comb begin
    cur_d = cur_q;
    idx_d = idx_q;
    jdx_d = jdx_q;
    ent_d = ent_q;
    fill_d = fill_q;
    found_d = found_q;
    mhop_d = mhop_q;
    mmet_d = mmet_q;
    inv_dest_d = inv_dest_q;
    res_d = res_q;
    out_d = out_q;
    out_valid_d = out_valid_q && !out_ch.ready;
    q_pop_o = 1'b0;
    we_dest = 1'b0;
    we_hop = 1'b0;
    we_met = 1'b0;
    we_age = 1'b0;
    waddr = idx_q;
    wdest = cur_q.item.dest_address;
    whop = cur_q.item.source_address;
    wmet = COST_INF;
    wage = '0;

    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cur_d = q_entry_i;
          idx_d = '0;
          found_d = 1'b0;
          res_d = '0;
        end
      end
      // Search for the destination
      S_FIND_CHK: begin
        if (dest_hit) begin
          found_d = 1'b1;
          ent_d = idx_q;
          mhop_d = rd_hop;
          mmet_d = rd_met;
        end else if (!last_i) begin
          idx_d = idx_q + IW'(1);
        end
      end
      S_APPLY: begin
        idx_d = '0;
        case (cur_q.op)
          OP_ADV: begin
            if (!found_q) begin
              if (tbl_full) begin
                res_d.table_full = 1'b1;
              end else begin
                waddr = IW'(fill_q);
                we_dest = 1'b1;
                we_hop = 1'b1;
                we_met = 1'b1;
                we_age = 1'b1;
                wmet = sat_cost;
                fill_d = fill_q + CW'(1);
                res_d.changed = 1'b1;
              end
            end else if (improve) begin
              waddr = ent_q;
              we_hop = 1'b1;
              we_met = 1'b1;
              wmet = sat_cost;
              res_d.changed = 1'b1;
            end else if (cur_q.item.adv_cost >= ADV_W'(COST_INF)) begin
              waddr = ent_q;
              we_met = 1'b1;
            end
          end
          OP_LOOKUP: begin
            res_d.found = found_q;
            res_d.next_hop = found_q ? mhop_q : '0;
            res_d.route_cost = found_q ? mmet_q : COST_INF;
          end
          OP_LINK: begin
            if (cur_q.item.link_up) begin
              if (found_q) begin
                waddr = ent_q;
                we_met = 1'b1;
                we_age = 1'b1;
                wmet = COST_DIRECT;
              end else if (tbl_full) begin
                res_d.table_full = 1'b1;
              end else begin
                waddr = IW'(fill_q);
                we_dest = 1'b1;
                we_hop = 1'b1;
                we_met = 1'b1;
                we_age = 1'b1;
                whop = cur_q.item.dest_address;
                wmet = COST_DIRECT;
                fill_d = fill_q + CW'(1);
              end
            end else if (found_q) begin
              waddr = ent_q;
              we_met = 1'b1;
            end
          end
          default: ;
        endcase
      end
      // Refresh the neighbor and every route through it
      S_KA_CHK: begin
        if (idx_q == ent_q) begin
          we_met = 1'b1;
          we_age = 1'b1;
          wmet = COST_DIRECT;
        end else if (rd_hop == cur_q.item.dest_address) begin
          we_age = 1'b1;
        end
        if (!last_i) idx_d = idx_q + IW'(1);
      end
      // Age every route, saturating
      S_AGE_CHK: begin
        we_age = 1'b1;
        wage = (rd_age == AGE_MAX) ? AGE_MAX : rd_age + AGE_W'(1);
        idx_d = last_i ? '0 : idx_q + IW'(1);
      end
      // Expire a route and drop routes through it
      S_EXP_CHK: begin
        if (expired) begin
          we_met = 1'b1;
          inv_dest_d = rd_dest;
          jdx_d = '0;
        end else if (!last_i) begin
          idx_d = idx_q + IW'(1);
        end
      end
      S_INV_CHK: begin
        if (rd_hop == inv_dest_q) begin
          waddr = jdx_q;
          we_met = 1'b1;
        end
        if (!last_j) jdx_d = jdx_q + IW'(1);
        else if (!last_i) idx_d = idx_q + IW'(1);
      end
      // Hand the result to the output register
      S_DONE: begin
        if (out_free) begin
          out_d = res_q;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    jdx_q <= jdx_d;
    ent_q <= ent_d;
    mhop_q <= mhop_d;
    mmet_q <= mmet_d;
    inv_dest_q <= inv_dest_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q <= '0;
      fill_q <= '0;
      found_q <= 1'b0;
      out_valid_q <= 1'b0;
      expire_q <= EXPIRE_RESET;
    end else begin
      state_q <= state_d;
      idx_q <= idx_d;
      fill_q <= fill_d;
      found_q <= found_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) expire_q <= cfg_wdata_i;
    end
  end

  assign out_ch.valid = out_valid_q;
  assign out_ch.changed = out_q.changed;
  assign out_ch.found = out_q.found;
  assign out_ch.next_hop = out_q.next_hop;
  assign out_ch.route_cost = out_q.route_cost;
  assign out_ch.table_full = out_q.table_full;

endmodule

// ===== design/distance_vector_route_table.sv =====
`timescale 1ns / 1ps
// Distance-vector route table. Commands enter through a two-deep queue and are
// carried out one at a time by a sequencer that walks the occupied entries,
// each in a read state and then a check state. A lookup, advertisement or
// link-state command searches for its destination, then applies; a keepalive
// that finds its neighbor then refreshes the routes through it; a tick ages
// every route, then scans for expired ones, each expiry rescanning the table
// for routes through it. Results leave through a registered output, so the
// queue keeps taking commands while a result waits. Entries fill from slot 0
// and are never freed, so a fill count replaces per-entry valid bits.
module distance_vector_route_table
  import drt_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [5:0] cfg_wdata_i,
  drt_in_if.sink     in_ch,
  drt_out_if.source  out_ch
);

  logic  q_valid, q_pop;
  qent_t q_entry;

  // Accept and classify commands
  drt_cmd_fifo u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_ch     (in_ch),
    .q_valid_o (q_valid),
    .q_entry_o (q_entry),
    .q_pop_i   (q_pop)
  );

  // Execute commands against the table
  drt_engine #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_entry),
    .q_pop_o     (q_pop),
    .out_ch      (out_ch)
  );

endmodule

// ===== design/drt_checker.sv =====
`timescale 1ns / 1ps
module drt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid,
  input logic        out_ready,
  input logic        changed,
  input logic        found,
  input logic [31:0] next_hop,
  input logic [4:0]  route_cost,
  input logic        table_full
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(next_hop) && $stable(route_cost))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> route_cost <= 5'd16)
    else $error("route cost above unreachable");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && found |-> route_cost != 5'd0 && !changed && !table_full)
    else $error("found route with bad cost or flags");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !(changed && table_full))
    else $error("insert both changed and dropped");

endmodule

bind distance_vector_route_table drt_checker u_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .changed    (out_ch.changed),
  .found      (out_ch.found),
  .next_hop   (out_ch.next_hop),
  .route_cost (out_ch.route_cost),
  .table_full (out_ch.table_full)
);
